// ===== rtl/nkm_pkg.sv =====
// Shared constants and types for the nearest key match set.
// No dependencies.
package nkm_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 30;
  localparam int TOT_W    = 20;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DIV_W    = KEY_W + 1;
  localparam int MOD_W    = TOT_W + 1;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  localparam logic [TOT_W-1:0] MODULUS_RESET = TOT_W'(1000000);

  localparam logic [1:0] ST_INSERT = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_DROP   = 2'd2;

  typedef logic [KEY_W-1:0] key_t;

endpackage

// ===== rtl/nkm_ram.sv =====
// Key store: one write port, one read port, registered read data.
// Depends on nkm_pkg.
module nkm_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [nkm_pkg::ADDR_W-1:0] waddr,
  input  nkm_pkg::key_t              wdata,
  input  logic [nkm_pkg::ADDR_W-1:0] raddr,
  output nkm_pkg::key_t              rdata
);
  import nkm_pkg::*;

  key_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nkm_mod.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nkm_pkg.
module nkm_mod (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nkm_pkg::DIV_W-1:0] dividend,
  input  logic [nkm_pkg::TOT_W-1:0] modulus,
  output logic                      done,
  output logic [nkm_pkg::TOT_W-1:0] result
);
  import nkm_pkg::*;

  logic              active;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  dv;
  logic [MOD_W-1:0]  rem;
  logic [MOD_W-1:0]  m;
  logic [MOD_W:0]    trial;
  logic [MOD_W-1:0]  rem_next;

  always_ff @(posedge clk) begin
    if (start) begin
      m <= (modulus == '0) ? (MOD_W'(1) << TOT_W) : {1'b0, modulus};
    end
  end

  always_comb begin
    trial = {rem, dv[DIV_W-1]};
    if (trial >= {1'b0, m}) begin
      rem_next = MOD_W'(trial - {1'b0, m});
    end else begin
      rem_next = trial[MOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= STEP_W'(DIV_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= dividend;
      rem <= '0;
    end else if (active) begin
      dv  <= dv << 1;
      rem <= rem_next;
    end
  end

  assign result = rem[TOT_W-1:0];

endmodule

// ===== rtl/nearest_key_match_set.sv =====
// Nearest key match set: waiting keys in one RAM, matched by nearest distance.
// Insert/drop: result registered in the cycle after start. Match: a linear scan
// of the RAM, one entry a cycle, a move of the last entry into the freed slot,
// then a serial modulo of the new total. One item at a time; busy while working.
// Synchronous reset clears the count, waiting kind and total, and sets the modulus
// to 1000000; store contents are undefined until written. Results cannot be stalled.
module nearest_key_match_set (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  nkm_pkg::key_t             key,
  output logic                      done,
  output logic [1:0]                status,
  output nkm_pkg::key_t             matched_key,
  output nkm_pkg::key_t             distance,
  output logic [nkm_pkg::TOT_W-1:0] running_total,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import nkm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_MOD     = 5'b10000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  entry_count;
  logic              waiting_kind;
  logic [TOT_W-1:0]  distance_total;
  logic [TOT_W-1:0]  total_modulus;
  key_t              req_key;
  logic [CNT_W-1:0]  scan_idx;
  logic              rv;
  logic [ADDR_W-1:0] rv_idx;
  logic              best_valid;
  key_t              best_key;
  key_t              best_d;
  logic [ADDR_W-1:0] pick;

  logic              accept;
  logic              eff_kind;
  logic              issue;
  key_t              q;
  key_t              d;
  logic              better;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  key_t              wdata;
  logic [ADDR_W-1:0] raddr;
  logic              mod_start;
  logic              mod_done;
  logic [TOT_W-1:0]  mod_result;
  logic [CNT_W-1:0]  last_idx;

  assign pready = 1'b1;
  assign prdata = {{(32-TOT_W){1'b0}}, total_modulus};
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign eff_kind = (entry_count == '0) ? kind : waiting_kind;
  assign issue  = (scan_idx < entry_count);
  assign last_idx = entry_count - 1'b1;

  always_comb begin
    d = (q >= req_key) ? (q - req_key) : (req_key - q);
    better = !best_valid || (d < best_d) || ((d == best_d) && (q < best_key));
  end

  always_comb begin
    we    = 1'b0;
    waddr = entry_count[ADDR_W-1:0];
    wdata = key;
    raddr = scan_idx[ADDR_W-1:0];
    if (state == S_MOVE_RD) begin
      raddr = last_idx[ADDR_W-1:0];
    end
    if (accept && (kind == eff_kind) && (entry_count != CNT_W'(CAPACITY))) begin
      we = 1'b1;
    end else if (state == S_MOVE_WR) begin
      we    = 1'b1;
      waddr = pick;
      wdata = q;
    end
  end

  assign mod_start = (state == S_MOVE_WR);

  nkm_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (q)
  );

  nkm_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend ({{(DIV_W-TOT_W){1'b0}}, distance_total} + {1'b0, best_d}),
    .modulus  (total_modulus),
    .done     (mod_done),
    .result   (mod_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total_modulus <= MODULUS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      total_modulus <= pwdata[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entry_count    <= '0;
      waiting_kind   <= 1'b0;
      distance_total <= '0;
      done           <= 1'b0;
      rv             <= 1'b0;
      best_valid     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_key      <= key;
            waiting_kind <= eff_kind;
            if (kind == eff_kind) begin
              done          <= 1'b1;
              matched_key   <= '0;
              distance      <= '0;
              running_total <= distance_total;
              if (entry_count == CNT_W'(CAPACITY)) begin
                status <= ST_DROP;
              end else begin
                status      <= ST_INSERT;
                entry_count <= entry_count + 1'b1;
              end
            end else begin
              scan_idx   <= '0;
              rv         <= 1'b0;
              best_valid <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rv     <= issue;
          rv_idx <= scan_idx[ADDR_W-1:0];
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (rv && better) begin
            best_valid <= 1'b1;
            best_key   <= q;
            best_d     <= d;
            pick       <= rv_idx;
          end
          if (!issue && !rv) begin
            state <= S_MOVE_RD;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          entry_count <= last_idx;
          state       <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            distance_total <= mod_result;
            done           <= 1'b1;
            status         <= ST_MATCH;
            matched_key    <= best_key;
            distance       <= best_d;
            running_total  <= mod_result;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_MOD)
    else $error("modulo result outside match flow");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_MATCH) |-> (matched_key == '0 && distance == '0))
    else $error("nonzero match fields on insert or drop");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted item left no trace");

endmodule
